// ===== rtl/rs_pkg.sv =====
// rs_pkg: shared types and constants for the reversible stack
// command and status codes, controller state, controller/datapath structs
// no dependencies
package rs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 7;

  // command carried in the input word's tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_REV  = 2'd2,
    FN_LIST = 2'd3
  } func_t;

  // result status
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    push_wr;       // write push value, grow stack
    logic    pop_rd;        // read top entry, shrink stack
    logic    rev;           // toggle direction flag
    logic    list_first;    // read top entry, start list cursor
    logic    list_next;     // read at cursor, advance cursor
    logic    out_load;      // load output register
    logic    out_use_rd;    // output data from memory read, else zero
    status_t out_status;
    logic    out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic list_last;        // one entry left to list
    logic out_valid;
  } dp_stat_t;

endpackage

// ===== rtl/reversible_stack.sv =====
// reversible_stack: top level of the last-in first-out store with reverse
// instantiates rs_ctrl and rs_dpath, depends on rs_pkg
//
// A stack of up to DEPTH signed 32-bit words held in a ring memory with a
// bottom pointer, a count and a direction flag, so reverse only toggles the
// flag whatever the fill. Each input word carries a command in tuser (push,
// pop, reverse, list) and the push value in tdata. Push, reverse, and any
// command refused for an empty or full stack load the result on acceptance;
// pop loads it from S_POP, via the memory's registered read port. List of n
// entries yields n result words top first, tlast on the final one, and holds
// the block until its last word is loaded, one entry per cycle through the
// single read port while the result side keeps tready high. Every result
// word carries the entry count and an empty flag as they stand after the
// command. The block takes a new command once the previous one has been
// issued and the output register is free or being emptied in the same cycle.
module reversible_stack #(
  parameter int DEPTH = rs_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data_out, [38:32] entry_count, [39] is_empty
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // is_last
);
  import rs_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [DATA_W-1:0]  out_data;
  status_t            out_status;
  logic [COUNT_W-1:0] out_count;
  logic               out_empty;

  // command sequencer
  rs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  // memory, pointers and output register
  rs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_tdata),
    .out_tready (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_tlast),
    .out_count  (out_count),
    .out_empty  (out_empty)
  );

  // result word packing
  assign out_tdata = {out_empty, out_count, out_data};
  assign out_tuser = out_status;

  // refused push reports a full stack
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> out_tdata[38:32] == COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  // empty status is a single final word with empty flag
  a_empty_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_EMPTY |-> out_tlast && out_tdata[39])
    else $error("empty status without last or empty flag");

  // push gives its result in the next cycle
  a_push_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FN_PUSH |=> out_tvalid && out_tlast)
    else $error("push result missing");

  // no command taken in the middle of a list run
  a_list_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted during list");

endmodule

// ===== rtl/rs_dpath.sv =====
// rs_dpath: entry memory, ring pointers, list cursor and output register
// depends on rs_pkg
module rs_dpath #(
  parameter int DEPTH = rs_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rs_pkg::dp_cmd_t               cmd,
  input  logic [rs_pkg::DATA_W-1:0]     push_value,
  input  logic                          out_tready,
  output rs_pkg::dp_stat_t              stat,
  output logic                          out_valid,
  output logic [rs_pkg::DATA_W-1:0]     out_data,
  output rs_pkg::status_t               out_status,
  output logic                          out_last,
  output logic [rs_pkg::COUNT_W-1:0]    out_count,
  output logic                          out_empty
);
  import rs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // ring helpers
  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rdata_r;

  logic [PTR_W-1:0]   bp_r, bp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               flip_r, flip_nxt;
  logic [PTR_W-1:0]   cursor_r, cursor_nxt;
  logic [CNT_W-1:0]   remain_r, remain_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r;
  status_t            out_status_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_empty_r;

  logic [PTR_W-1:0]   top_slot;
  logic [PTR_W-1:0]   wr_slot;
  logic [PTR_W-1:0]   rd_addr;
  logic               rd_en;

  // slot of the top entry and of the next push
  always_comb begin
    top_slot = flip_r ? bp_r : ring_add(bp_r, cnt_r - 1'b1);
    wr_slot  = flip_r ? ring_dec(bp_r) : ring_add(bp_r, cnt_r);
    rd_en    = cmd.pop_rd | cmd.list_first | cmd.list_next;
    rd_addr  = cmd.list_next ? cursor_r : top_slot;
  end

  // pointer, count and cursor updates
  always_comb begin
    bp_nxt     = bp_r;
    cnt_nxt    = cnt_r;
    flip_nxt   = flip_r;
    cursor_nxt = cursor_r;
    remain_nxt = remain_r;
    if (cmd.push_wr) begin
      cnt_nxt = cnt_r + 1'b1;
      if (flip_r) begin
        bp_nxt = ring_dec(bp_r);
      end
    end
    if (cmd.pop_rd) begin
      cnt_nxt = cnt_r - 1'b1;
      if (flip_r) begin
        bp_nxt = ring_inc(bp_r);
      end
    end
    if (cmd.rev) begin
      flip_nxt = ~flip_r;
    end
    // list walks from the top toward the bottom
    if (cmd.list_first) begin
      cursor_nxt = flip_r ? ring_inc(top_slot) : ring_dec(top_slot);
      remain_nxt = cnt_r;
    end
    if (cmd.list_next) begin
      cursor_nxt = flip_r ? ring_inc(cursor_r) : ring_dec(cursor_r);
      remain_nxt = remain_r - 1'b1;
    end
  end

  // output valid
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r        <= '0;
      cnt_r       <= '0;
      flip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bp_r        <= bp_nxt;
      cnt_r       <= cnt_nxt;
      flip_r      <= flip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // list cursor
  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    remain_r <= remain_nxt;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[wr_slot] <= push_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= cmd.out_use_rd ? rdata_r : '0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      out_count_r  <= COUNT_W'(cnt_nxt);
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  // status toward the controller
  always_comb begin
    stat.full      = (cnt_r == CNT_W'(DEPTH));
    stat.empty     = (cnt_r == '0);
    stat.list_last = (remain_r == CNT_W'(1));
    stat.out_valid = out_valid_r;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;

endmodule

// ===== rtl/rs_ctrl.sv =====
// rs_ctrl: command sequencer for the reversible stack
// depends on rs_pkg
module rs_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [rs_pkg::FUNC_W-1:0] in_func,
  input  logic                      out_tready,
  input  rs_pkg::dp_stat_t          stat,
  output logic                      in_tready,
  output rs_pkg::dp_cmd_t           cmd
);
  import rs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_free;
  logic   accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    out_free       = ~stat.out_valid | out_tready;
    in_tready      = (state_r == S_IDLE) & out_free;
    accept         = in_tvalid & in_tready;
    state_nxt      = state_r;
    cmd            = '0;
    cmd.out_status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.out_last = 1'b1;
          case (func_t'(in_func))
            FN_PUSH: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = STAT_FULL;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            FN_POP: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STAT_EMPTY;
              end else begin
                cmd.pop_rd = 1'b1;
                state_nxt  = S_POP;
              end
            end
            FN_REV: begin
              cmd.rev      = 1'b1;
              cmd.out_load = 1'b1;
            end
            FN_LIST: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STAT_EMPTY;
              end else begin
                cmd.list_first = 1'b1;
                state_nxt      = S_LIST;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      // popped word arrives from the memory read register
      S_POP: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // one listed entry per free output slot, next read overlapped
      S_LIST: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = stat.list_last;
          if (stat.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.list_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
